@@ rtl/stq_pkg.sv @@
// ============================================================================
// stq_pkg
// Shared types and codes of the sorted timer queue.
// ============================================================================
package stq_pkg;

    localparam int ID_W   = 4;
    localparam int DUR_W  = 32;
    localparam int OP_W   = 2;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd4;

    localparam logic [DUR_W-1:0] MIN_PERIOD_RST = 32'd100000;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_DEL,
        CMD_TICK,
        CMD_REJ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ID_W-1:0]   id;
        logic              periodic;
        logic [DUR_W-1:0]  dur;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_fifo_ctl;

endpackage

@@ rtl/stq_front.sv @@
// ============================================================================
// stq_front
// Accepts input words, classifies them into commands and rejects bad adds.
// ============================================================================
module stq_front
    import stq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic              i_periodic,
    input  logic [DUR_W-1:0]  i_duration,
    input  logic [DUR_W-1:0]  i_min_period,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic w_bad;

    assign o_ready = !i_full;
    assign w_bad   = (int'(i_timer_id) >= DEPTH) || (i_periodic && (i_duration < i_min_period));

    always_comb begin
        o_cmd.id       = i_timer_id;
        o_cmd.periodic = i_periodic;
        o_cmd.dur      = i_duration;
        o_cmd.kind     = CMD_TICK;
        o_push         = i_valid && !i_full;
        case (i_op)
            OP_ADD:  o_cmd.kind = w_bad ? CMD_REJ : CMD_ADD;
            OP_DEL:  o_cmd.kind = CMD_DEL;
            OP_TICK: o_cmd.kind = CMD_TICK;
            // drop the unused code
            default: o_push = 1'b0;
        endcase
    end

endmodule

@@ rtl/stq_cmd_fifo.sv @@
// ============================================================================
// stq_cmd_fifo
// Two-entry command queue between the front and the engine.
// ============================================================================
module stq_cmd_fifo
    import stq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/stq_engine.sv @@
// ============================================================================
// stq_engine
// Executes commands over the slot table with a slot-serial walk and drives
// the result register.
// ============================================================================
module stq_engine
    import stq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [KIND_W-1:0]      o_kind,
    output logic [ID_W-1:0]        o_fired_id,
    output logic [TIME_BITS-1:0]   o_next_deadline,
    output logic                   o_rearm,
    output logic                   o_last,
    output logic [DEPTH-1:0]       o_active,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCHED,
        S_BEST,
        S_ENQ,
        S_PICK,
        S_RESP
    } t_state;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [DUR_W-1:0]     b
    );
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS + 1)'(b);
        sat_add = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    t_state                 r_state;
    logic [TIME_BITS-1:0]   r_time;
    logic [DEPTH-1:0]       r_act;
    logic [DEPTH-1:0]       r_per;
    logic [DEPTH-1:0]       r_fired;
    logic [DUR_W-1:0]       r_prd  [DEPTH];
    logic [TIME_BITS-1:0]   r_when [DEPTH];
    logic [SW-1:0]          r_ord  [DEPTH];
    logic [CW-1:0]          r_cnt;

    logic [SW-1:0]          r_idx;
    logic [SW-1:0]          r_sid;
    logic [ID_W-1:0]        r_rid;
    logic [KIND_W-1:0]      r_rk;
    logic                   r_flag;
    logic [SW-1:0]          r_pos;
    logic                   r_bfound;
    logic [SW-1:0]          r_bid;
    logic [SW-1:0]          r_bord;

    logic                   r_ovalid;
    logic [KIND_W-1:0]      r_okind;
    logic [ID_W-1:0]        r_oid;
    logic [TIME_BITS-1:0]   r_ond;
    logic                   r_orearm;
    logic                   r_olast;

    logic [TIME_BITS-1:0]   w_head_when;
    logic [SW-1:0]          w_cid;
    logic                   w_elig;
    logic                   w_take;
    logic                   w_nfound;
    logic [SW-1:0]          w_nid;
    logic [SW-1:0]          w_nord;
    logic [SW-1:0]          w_npos;
    logic                   w_last_idx;
    logic                   w_out_free;
    logic                   w_unq;
    logic [SW-1:0]          w_uid;
    logic                   w_rearm;

    assign w_cid      = SW'(i_cmd.id);
    assign w_last_idx = (r_idx == LAST_IDX);
    assign w_out_free = !r_ovalid || i_ready;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        w_head_when = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_act[i] && (r_ord[i] == '0)) begin
                w_head_when = w_head_when | r_when[i];
            end
        end
    end

    // candidate of the running minimum-order search
    always_comb begin
        w_elig = 1'b0;
        case (r_state)
            S_PICK:  w_elig = r_act[r_idx] && !r_fired[r_idx] && (r_when[r_idx] <= r_time);
            S_BEST:  w_elig = r_act[r_idx] && r_per[r_idx] && (r_prd[r_idx] == r_prd[r_sid]);
            default: w_elig = 1'b0;
        endcase
        w_take   = w_elig && (!r_bfound || (r_ord[r_idx] < r_bord));
        w_nfound = r_bfound || w_elig;
        w_nid    = w_take ? r_idx : r_bid;
        w_nord   = w_take ? r_ord[r_idx] : r_bord;
        w_npos   = r_pos + SW'(r_act[r_idx] && (r_when[r_idx] <= r_when[r_sid]));
    end

    always_comb begin
        w_unq = 1'b0;
        w_uid = w_cid;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && r_act[w_cid]) begin
                    w_unq = (i_cmd.kind == CMD_ADD) ||
                            ((i_cmd.kind == CMD_DEL) && (int'(i_cmd.id) < DEPTH));
                end
            end
            S_PICK: begin
                w_unq = w_last_idx && w_nfound;
                w_uid = w_nid;
            end
            default: w_unq = 1'b0;
        endcase
    end

    always_comb begin
        case (r_rk)
            KIND_ADDED:     w_rearm = r_flag;
            KIND_DELETED:   w_rearm = r_flag && (r_cnt != '0);
            KIND_TICK_DONE: w_rearm = (r_cnt != '0);
            default:        w_rearm = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_act    <= '0;
            r_per    <= '0;
            r_fired  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_bfound <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_prd[i]  <= '0;
                r_when[i] <= '0;
                r_ord[i]  <= '0;
            end
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            if (w_unq) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (r_act[i] && (r_ord[i] > r_ord[w_uid])) begin
                        r_ord[i] <= r_ord[i] - 1'b1;
                    end
                end
                r_act[w_uid] <= 1'b0;
                r_cnt        <= r_cnt - 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_rid  <= i_cmd.id;
                        r_sid  <= w_cid;
                        r_flag <= 1'b0;
                        case (i_cmd.kind)
                            CMD_ADD: begin
                                r_rk         <= KIND_ADDED;
                                r_per[w_cid] <= i_cmd.periodic;
                                r_prd[w_cid] <= i_cmd.dur;
                                r_state      <= S_SCHED;
                            end
                            CMD_DEL: begin
                                r_rk    <= KIND_DELETED;
                                r_flag  <= w_unq && (r_ord[w_cid] == '0);
                                r_state <= S_RESP;
                            end
                            CMD_TICK: begin
                                r_time   <= sat_add(r_time, DUR_W'(1));
                                r_fired  <= '0;
                                r_idx    <= '0;
                                r_bfound <= 1'b0;
                                r_state  <= S_PICK;
                            end
                            default: begin
                                r_rk    <= KIND_REJECTED;
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCHED: begin
                    r_idx    <= '0;
                    r_pos    <= '0;
                    r_bfound <= 1'b0;
                    if (!r_per[r_sid]) begin
                        r_when[r_sid] <= sat_add(r_time,
                            (r_prd[r_sid] == '0) ? DUR_W'(1) : r_prd[r_sid]);
                        r_state <= S_ENQ;
                    end else if (r_when[r_sid] != '0) begin
                        r_when[r_sid] <= sat_add(r_when[r_sid], r_prd[r_sid]);
                        r_state <= S_ENQ;
                    end else begin
                        r_state <= S_BEST;
                    end
                end
                S_BEST: begin
                    r_bfound <= w_nfound;
                    r_bid    <= w_nid;
                    r_bord   <= w_nord;
                    r_idx    <= r_idx + 1'b1;
                    if (w_last_idx) begin
                        // align to the first queued timer of the same period
                        r_when[r_sid] <= sat_add(w_nfound ? r_when[w_nid] : r_time,
                                                 r_prd[r_sid]);
                        r_idx   <= '0;
                        r_pos   <= '0;
                        r_state <= S_ENQ;
                    end
                end
                S_ENQ: begin
                    r_pos <= w_npos;
                    r_idx <= r_idx + 1'b1;
                    if (w_last_idx) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (r_act[i] && (r_ord[i] >= w_npos)) begin
                                r_ord[i] <= r_ord[i] + 1'b1;
                            end
                        end
                        r_ord[r_sid] <= w_npos;
                        r_act[r_sid] <= 1'b1;
                        r_cnt        <= r_cnt + 1'b1;
                        r_flag       <= (w_npos == '0);
                        r_state      <= S_RESP;
                    end
                end
                S_PICK: begin
                    r_bfound <= w_nfound;
                    r_bid    <= w_nid;
                    r_bord   <= w_nord;
                    r_idx    <= r_idx + 1'b1;
                    if (w_last_idx) begin
                        if (w_nfound) begin
                            r_fired[w_nid] <= 1'b1;
                            r_sid          <= w_nid;
                            r_rid          <= ID_W'(w_nid);
                            r_rk           <= KIND_FIRED;
                            r_state        <= r_per[w_nid] ? S_SCHED : S_RESP;
                        end else begin
                            r_rid   <= '0;
                            r_rk    <= KIND_TICK_DONE;
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_rk;
                        r_oid    <= r_rid;
                        r_ond    <= w_head_when;
                        r_orearm <= w_rearm;
                        r_olast  <= (r_rk != KIND_FIRED);
                        r_idx    <= '0;
                        r_bfound <= 1'b0;
                        // keep walking for further due timers
                        r_state  <= (r_rk == KIND_FIRED) ? S_PICK : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_kind          = r_okind;
    assign o_fired_id      = r_oid;
    assign o_next_deadline = r_ond;
    assign o_rearm         = r_orearm;
    assign o_last          = r_olast;
    assign o_active        = r_act;
    assign o_count         = r_cnt;

endmodule

@@ rtl/sorted_timer_queue_top.sv @@
// ============================================================================
// sorted_timer_queue_top
// Deadline-ordered timer queue with tick counter and APB configuration.
// ============================================================================
// Timers live in DEPTH slots kept in deadline order (first in, first out on
// equal deadlines). Input words are classified on entry and queued two deep,
// so the input side keeps accepting while a result waits. The engine walks
// the slot table one slot per cycle: an add walks it once (twice for a
// periodic timer aligning to a peer), a delete not at all, and a tick once
// plus once more per fired timer (twice for periodic re-queueing). Register
// 0 at byte address 0 is min_period.
module sorted_timer_queue_top
    import stq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic [ID_W-1:0]       i_timer_id,
    input  logic                  i_periodic,
    input  logic [DUR_W-1:0]      i_duration,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [ID_W-1:0]       o_fired_id,
    output logic [TIME_BITS-1:0]  o_next_deadline,
    output logic                  o_rearm,
    output logic                  o_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [DUR_W-1:0]          r_min_period;
    t_fifo_ctl                 w_fctl;
    t_cmd                      w_front_cmd;
    t_cmd                      w_head_cmd;
    logic                      w_empty;
    logic                      w_pop;
    logic [DEPTH-1:0]          w_active;
    logic [$clog2(DEPTH+1)-1:0] w_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_min_period : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_min_period <= pwdata;
        end
    end

    stq_front #(.DEPTH(DEPTH)) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_timer_id   (i_timer_id),
        .i_periodic   (i_periodic),
        .i_duration   (i_duration),
        .i_min_period (r_min_period),
        .i_full       (w_fctl.full),
        .o_push       (w_fctl.push),
        .o_cmd        (w_front_cmd)
    );

    stq_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fctl.push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_fctl.full),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    stq_engine #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (!w_empty),
        .i_cmd           (w_head_cmd),
        .o_cmd_pop       (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_fired_id      (o_fired_id),
        .o_next_deadline (o_next_deadline),
        .o_rearm         (o_rearm),
        .o_last          (o_last),
        .o_active        (w_active),
        .o_count         (w_count)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fctl.push && w_fctl.full))
        else $error("command queue overflow");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_active) == int'(w_count))
        else $error("queue count disagrees with active slots");

    a_only_fire_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == KIND_FIRED)
        else $error("non-final result that is not a firing");

    a_empty_no_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && (w_count == '0) |-> !o_rearm)
        else $error("rearm with empty queue");

endmodule
